FILE: rtl/pae_pkg.sv
// Package for the packed archive entry decoder.
// Holds the flag word layout, the parse phases and the result type.
// No dependencies.
package pae_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);
  localparam int unsigned FifoCw    = $clog2(FifoDepth + 1);

  localparam logic [5:0]  InlineSizeCode = 6'h3F;
  localparam int unsigned CodeShift      = 11;
  localparam logic [20:0] HdrBytes       = 21'd53;
  localparam logic [20:0] HdrMethodBytes = 21'd57;

  localparam int unsigned FlagOffWordBit    = 31;
  localparam int unsigned FlagPlainWordBit  = 30;
  localparam int unsigned FlagPackedWordBit = 29;
  localparam int unsigned FlagEncBit        = 22;

  localparam logic KindHeader = 1'b0;
  localparam logic KindBlock  = 1'b1;

  typedef enum logic [8:0] {
    PhFlag     = 9'b000000001,
    PhBsize    = 9'b000000010,
    PhOffLo    = 9'b000000100,
    PhOffHi    = 9'b000001000,
    PhPlainLo  = 9'b000010000,
    PhPlainHi  = 9'b000100000,
    PhPackedLo = 9'b001000000,
    PhPackedHi = 9'b010000000,
    PhBlocks   = 9'b100000000
  } phase_e;

  typedef struct packed {
    logic        kind;
    logic [63:0] entry_offset;
    logic [63:0] plain_size;
    logic [63:0] packed_size;
    logic [5:0]  method;
    logic        encrypted;
    logic [63:0] chunk_size;
    logic [15:0] chunk_count;
    logic [63:0] chunk_start;
    logic [63:0] chunk_end;
    logic        last;
  } res_t;

endpackage

FILE: rtl/pae_if.sv
// Channel interfaces for the packed archive entry decoder.
// pae_word_if carries input words, pae_res_if carries result words; no dependencies.
interface pae_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

interface pae_res_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [63:0] entry_offset;
  logic [63:0] plain_size;
  logic [63:0] packed_size;
  logic [5:0]  method;
  logic        encrypted;
  logic [63:0] chunk_size;
  logic [15:0] chunk_count;
  logic [63:0] chunk_start;
  logic [63:0] chunk_end;
  logic        last;

  modport source (output valid, input ready, output kind, output entry_offset,
                  output plain_size, output packed_size, output method,
                  output encrypted, output chunk_size, output chunk_count,
                  output chunk_start, output chunk_end, output last);
  modport sink (input valid, output ready, input kind, input entry_offset,
                input plain_size, input packed_size, input method,
                input encrypted, input chunk_size, input chunk_count,
                input chunk_start, input chunk_end, input last);
endinterface

FILE: rtl/packed_archive_entry_decoder.sv
// Packed archive entry decoder, top level.
// Depends on pae_pkg and the channel interfaces in pae_if.sv.
//
// Usage:
//   in_i  (pae_word_if.sink): 32-bit little-endian words of back-to-back
//         archive index entries. A word is taken when valid and ready are high.
//   out_o (pae_res_if.source): one header word per entry, then one block word
//         per compression block; last marks the final word of an entry.
//   Each input word is decoded in the cycle it is accepted; the state and the
//   results it produces are registered at that edge. Results reach out_o
//   through the result queue, in the order of the words that caused them.
//   Throughput: one input word per cycle. The word that completes an entry
//   with one unencrypted block yields two results, pushed together into a
//   four-entry result queue; in_i.ready is high while the queue has room for
//   two, so a steady one-word-per-cycle stream never stalls while out_o is
//   taken every cycle.
//   When the receiver stalls, results wait in the queue in order; input
//   is held off only once fewer than two places remain.
//   Reset (rst_ni low, asynchronous) empties the queue and returns the parser
//   to expecting a flag word. There is no resynchronisation on the stream.
module packed_archive_entry_decoder (
  input  logic            clk_i,
  input  logic            rst_ni,
  pae_word_if.sink        in_i,
  pae_res_if.source       out_o
);

  pae_pkg::phase_e phase_q, phase_d;
  logic [31:0] flag_q, flag_d;
  logic [31:0] low_q, low_d;
  logic [63:0] offset_q, offset_d;
  logic [63:0] plain_q, plain_d;
  logic [63:0] packed_q, packed_d;
  logic [31:0] csize_q, csize_d;
  logic [15:0] left_q, left_d;
  logic [63:0] pos_q, pos_d;
  logic [63:0] base_q, base_d;

  pae_pkg::res_t fifo_q [pae_pkg::FifoDepth];
  logic [pae_pkg::FifoAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [pae_pkg::FifoCw-1:0] cnt_q;

  logic        in_acc, pop;
  logic        push0, push1;
  logic        plain_done, fin;
  logic [31:0] w;
  logic [5:0]  method;
  logic        enc;
  logic [15:0] cnt;
  logic [20:0] hsize;
  logic [63:0] off_val;
  logic [63:0] csz;
  logic [32:0] rnd;
  pae_pkg::res_t r0, r1;
  logic [pae_pkg::FifoCw-1:0] npush;

  assign w      = in_i.word;
  assign method = flag_q[28:23];
  assign enc    = flag_q[pae_pkg::FlagEncBit];
  assign cnt    = flag_q[21:6];
  assign hsize  = (method != 6'd0) ? (pae_pkg::HdrMethodBytes + {1'b0, cnt, 4'b0000})
                                   : pae_pkg::HdrBytes;
  assign rnd    = ({1'b0, w} + 33'd15) & ~33'h0000_000F;

  assign in_i.ready = (cnt_q <= pae_pkg::FifoCw'(pae_pkg::FifoDepth - 2));
  assign in_acc     = in_i.valid && in_i.ready;

  always_comb begin
    phase_d    = phase_q;
    flag_d     = flag_q;
    low_d      = low_q;
    offset_d   = offset_q;
    plain_d    = plain_q;
    packed_d   = packed_q;
    csize_d    = csize_q;
    left_d     = left_q;
    pos_d      = pos_q;
    base_d     = base_q;
    plain_done = 1'b0;
    fin        = 1'b0;
    push0      = 1'b0;
    push1      = 1'b0;
    off_val    = {w, low_q};
    r0         = '0;
    r1         = '0;

    case (phase_q)
      pae_pkg::PhFlag: begin
        flag_d = w;
        if (w[5:0] == pae_pkg::InlineSizeCode) begin
          phase_d = pae_pkg::PhBsize;
        end else begin
          csize_d = 32'({w[5:0], {pae_pkg::CodeShift{1'b0}}});
          phase_d = pae_pkg::PhOffLo;
        end
      end
      pae_pkg::PhBsize: begin
        csize_d = w;
        phase_d = pae_pkg::PhOffLo;
      end
      pae_pkg::PhOffLo: begin
        if (flag_q[pae_pkg::FlagOffWordBit]) begin
          off_val  = {32'd0, w};
          offset_d = off_val;
          base_d   = off_val + 64'(hsize);
          phase_d  = pae_pkg::PhPlainLo;
        end else begin
          low_d   = w;
          phase_d = pae_pkg::PhOffHi;
        end
      end
      pae_pkg::PhOffHi: begin
        offset_d = off_val;
        base_d   = off_val + 64'(hsize);
        phase_d  = pae_pkg::PhPlainLo;
      end
      pae_pkg::PhPlainLo: begin
        if (flag_q[pae_pkg::FlagPlainWordBit]) begin
          plain_d    = {32'd0, w};
          plain_done = 1'b1;
        end else begin
          low_d   = w;
          phase_d = pae_pkg::PhPlainHi;
        end
      end
      pae_pkg::PhPlainHi: begin
        plain_d    = {w, low_q};
        plain_done = 1'b1;
      end
      pae_pkg::PhPackedLo: begin
        if (flag_q[pae_pkg::FlagPackedWordBit]) begin
          packed_d = {32'd0, w};
          fin      = 1'b1;
        end else begin
          low_d   = w;
          phase_d = pae_pkg::PhPackedHi;
        end
      end
      pae_pkg::PhPackedHi: begin
        packed_d = {w, low_q};
        fin      = 1'b1;
      end
      pae_pkg::PhBlocks: begin
        pos_d  = pos_q + (enc ? {31'd0, rnd} : {32'd0, w});
        left_d = left_q - 16'd1;
        push0  = 1'b1;
        if (left_d == 16'd0) begin
          phase_d = pae_pkg::PhFlag;
        end
      end
      default: begin
        phase_d = pae_pkg::PhFlag;
      end
    endcase

    if (plain_done) begin
      if (method != 6'd0) begin
        phase_d = pae_pkg::PhPackedLo;
      end else begin
        packed_d = plain_d;
        fin      = 1'b1;
      end
    end

    if (cnt == 16'd1) begin
      csz = plain_d;
    end else if (cnt > 16'd1) begin
      csz = {32'd0, csize_q};
    end else begin
      csz = 64'd0;
    end

    r0.entry_offset = offset_d;
    r0.plain_size   = plain_d;
    r0.packed_size  = packed_d;
    r0.method       = method;
    r0.encrypted    = enc;
    r0.chunk_size   = csz;
    r0.chunk_count  = cnt;
    r1              = r0;

    if (fin) begin
      push0   = 1'b1;
      r0.kind = pae_pkg::KindHeader;
      if (cnt == 16'd0) begin
        r0.last = 1'b1;
        phase_d = pae_pkg::PhFlag;
      end else if (cnt == 16'd1 && !enc) begin
        push1          = 1'b1;
        r1.kind        = pae_pkg::KindBlock;
        r1.chunk_start = base_q;
        r1.chunk_end   = base_q + packed_d;
        r1.last        = 1'b1;
        phase_d        = pae_pkg::PhFlag;
      end else begin
        pos_d   = base_q;
        left_d  = cnt;
        phase_d = pae_pkg::PhBlocks;
      end
    end else if (phase_q == pae_pkg::PhBlocks) begin
      r0.kind        = pae_pkg::KindBlock;
      r0.chunk_start = pos_q;
      r0.chunk_end   = pos_q + {32'd0, w};
      r0.last        = (left_d == 16'd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= pae_pkg::PhFlag;
      flag_q   <= '0;
      low_q    <= '0;
      offset_q <= '0;
      plain_q  <= '0;
      packed_q <= '0;
      csize_q  <= '0;
      left_q   <= '0;
      pos_q    <= '0;
      base_q   <= '0;
    end else if (in_acc) begin
      phase_q  <= phase_d;
      flag_q   <= flag_d;
      low_q    <= low_d;
      offset_q <= offset_d;
      plain_q  <= plain_d;
      packed_q <= packed_d;
      csize_q  <= csize_d;
      left_q   <= left_d;
      pos_q    <= pos_d;
      base_q   <= base_d;
    end
  end

  // result queue
  assign pop   = out_o.valid && out_o.ready;
  assign npush = in_acc ? (pae_pkg::FifoCw'(push0) + pae_pkg::FifoCw'(push1))
                        : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + pae_pkg::FifoAw'(npush);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + pae_pkg::FifoAw'(1);
      end
      cnt_q <= cnt_q + npush - pae_pkg::FifoCw'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && push0) begin
      fifo_q[wr_ptr_q] <= r0;
    end
    if (in_acc && push1) begin
      fifo_q[wr_ptr_q + pae_pkg::FifoAw'(1)] <= r1;
    end
  end

  assign out_o.valid        = (cnt_q != '0);
  assign out_o.kind         = fifo_q[rd_ptr_q].kind;
  assign out_o.entry_offset = fifo_q[rd_ptr_q].entry_offset;
  assign out_o.plain_size   = fifo_q[rd_ptr_q].plain_size;
  assign out_o.packed_size  = fifo_q[rd_ptr_q].packed_size;
  assign out_o.method       = fifo_q[rd_ptr_q].method;
  assign out_o.encrypted    = fifo_q[rd_ptr_q].encrypted;
  assign out_o.chunk_size   = fifo_q[rd_ptr_q].chunk_size;
  assign out_o.chunk_count  = fifo_q[rd_ptr_q].chunk_count;
  assign out_o.chunk_start  = fifo_q[rd_ptr_q].chunk_start;
  assign out_o.chunk_end    = fifo_q[rd_ptr_q].chunk_end;
  assign out_o.last         = fifo_q[rd_ptr_q].last;

  // checks
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= pae_pkg::FifoCw'(pae_pkg::FifoDepth))
    else $error("result queue overfilled");

  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("phase register not one-hot");

  a_blocks_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == pae_pkg::PhBlocks) |-> (left_q != 16'd0))
    else $error("block phase with no blocks left");

  a_last_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && phase_q == pae_pkg::PhBlocks && left_q == 16'd1)
      |=> (phase_q == pae_pkg::PhFlag && cnt_q != '0))
    else $error("final block did not close the entry");

  a_pair_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && push1) |-> (push0 && fin && !enc && cnt == 16'd1))
    else $error("second result pushed outside a single-block entry");

endmodule

FILE: sim/pae_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the packed archive entry decoder testbench.
// Decodes accepted input words itself, compares each result word in order.
// Depends on pae_pkg and the channel interfaces in pae_if.sv.
module pae_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  pae_word_if         word_bus,
  pae_res_if          res_bus,
  output int unsigned fail_count_o,
  output int unsigned results_due_o
);

  localparam int unsigned CountLsb  = 6;
  localparam int unsigned MethodLsb = 23;

  pae_pkg::phase_e phase_q;
  logic [31:0]     flag_q;
  logic [31:0]     low_q;
  logic [31:0]     bsize_q;
  logic [63:0]     offset_q;
  logic [63:0]     plain_q;
  logic [63:0]     stored_q;
  logic [63:0]     pos_q;
  logic [15:0]     left_q;
  pae_pkg::res_t   results_q[$];
  int unsigned     mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic logic [15:0] entry_count();
    return flag_q[CountLsb +: 16];
  endfunction

  function automatic logic [5:0] entry_method();
    return flag_q[MethodLsb +: 6];
  endfunction

  function automatic pae_pkg::res_t make_result(logic kind, logic [63:0] start,
                                                logic [63:0] stop, logic last);
    pae_pkg::res_t r;
    logic [15:0]   cnt;
    cnt           = entry_count();
    r.kind         = kind;
    r.entry_offset = offset_q;
    r.plain_size   = plain_q;
    r.packed_size  = stored_q;
    r.method       = entry_method();
    r.encrypted    = flag_q[pae_pkg::FlagEncBit];
    r.chunk_size   = (cnt == 16'd0) ? 64'd0 : (cnt == 16'd1) ? plain_q : {32'd0, bsize_q};
    r.chunk_count  = cnt;
    r.chunk_start  = start;
    r.chunk_end    = stop;
    r.last         = last;
    return r;
  endfunction

  task automatic close_header();
    logic [15:0] cnt;
    logic [63:0] base;
    cnt  = entry_count();
    base = offset_q + 64'(pae_pkg::HdrBytes);
    if (entry_method() != 6'd0) begin
      base = offset_q + 64'(pae_pkg::HdrMethodBytes) + {44'd0, cnt, 4'd0};
    end
    if (cnt == 16'd0) begin
      results_q = {results_q, make_result(pae_pkg::KindHeader, '0, '0, 1'b1)};
      phase_q = pae_pkg::PhFlag;
    end else if (cnt == 16'd1 && !flag_q[pae_pkg::FlagEncBit]) begin
      // single plain block: header and block in one go
      results_q = {results_q, make_result(pae_pkg::KindHeader, '0, '0, 1'b0)};
      results_q = {results_q,
                   make_result(pae_pkg::KindBlock, base, base + stored_q, 1'b1)};
      phase_q = pae_pkg::PhFlag;
    end else begin
      results_q = {results_q, make_result(pae_pkg::KindHeader, '0, '0, 1'b0)};
      pos_q   = base;
      left_q  = cnt;
      phase_q = pae_pkg::PhBlocks;
    end
  endtask

  task automatic plain_done();
    if (entry_method() != 6'd0) begin
      phase_q = pae_pkg::PhPackedLo;
    end else begin
      stored_q = plain_q;
      close_header();
    end
  endtask

  task automatic decode_word(input logic [31:0] w);
    logic [63:0] start;
    case (phase_q)
      pae_pkg::PhFlag: begin
        flag_q = w;
        if (w[5:0] == pae_pkg::InlineSizeCode) begin
          phase_q = pae_pkg::PhBsize;
        end else begin
          bsize_q = 32'(w[5:0]) << pae_pkg::CodeShift;
          phase_q = pae_pkg::PhOffLo;
        end
      end
      pae_pkg::PhBsize: begin
        bsize_q = w;
        phase_q = pae_pkg::PhOffLo;
      end
      pae_pkg::PhOffLo: begin
        if (flag_q[pae_pkg::FlagOffWordBit]) begin
          offset_q = {32'd0, w};
          phase_q  = pae_pkg::PhPlainLo;
        end else begin
          low_q   = w;
          phase_q = pae_pkg::PhOffHi;
        end
      end
      pae_pkg::PhOffHi: begin
        offset_q = {w, low_q};
        phase_q  = pae_pkg::PhPlainLo;
      end
      pae_pkg::PhPlainLo: begin
        if (flag_q[pae_pkg::FlagPlainWordBit]) begin
          plain_q = {32'd0, w};
          plain_done();
        end else begin
          low_q   = w;
          phase_q = pae_pkg::PhPlainHi;
        end
      end
      pae_pkg::PhPlainHi: begin
        plain_q = {w, low_q};
        plain_done();
      end
      pae_pkg::PhPackedLo: begin
        if (flag_q[pae_pkg::FlagPackedWordBit]) begin
          stored_q = {32'd0, w};
          close_header();
        end else begin
          low_q   = w;
          phase_q = pae_pkg::PhPackedHi;
        end
      end
      pae_pkg::PhPackedHi: begin
        stored_q = {w, low_q};
        close_header();
      end
      pae_pkg::PhBlocks: begin
        start = pos_q;
        // encrypted blocks advance by the size rounded up to 16
        if (flag_q[pae_pkg::FlagEncBit]) pos_q = pos_q + (({32'd0, w} + 64'd15) & ~64'd15);
        else pos_q = pos_q + {32'd0, w};
        left_q = left_q - 16'd1;
        results_q = {results_q, make_result(pae_pkg::KindBlock, start, start + {32'd0, w},
                                           left_q == 16'd0)};
        if (left_q == 16'd0) phase_q = pae_pkg::PhFlag;
      end
      default: phase_q = pae_pkg::PhFlag;
    endcase
  endtask

  task automatic compare_field(input string name, input logic [63:0] want_v,
                               input logic [63:0] seen_v);
    if (want_v !== seen_v) begin
      $error("%s: expected %0h, actual %0h", name, want_v, seen_v);
      mismatches++;
    end
  endtask

  task automatic check_result();
    pae_pkg::res_t seen;
    pae_pkg::res_t want;
    seen = {res_bus.kind, res_bus.entry_offset, res_bus.plain_size, res_bus.packed_size,
            res_bus.method, res_bus.encrypted, res_bus.chunk_size, res_bus.chunk_count,
            res_bus.chunk_start, res_bus.chunk_end, res_bus.last};
    if (results_q.size() == 0) begin
      $error("unexpected result word: kind %0d start %0h", seen.kind, seen.chunk_start);
      mismatches++;
      return;
    end
    want = results_q.pop_front();
    compare_field("kind", 64'(want.kind), 64'(seen.kind));
    compare_field("entry_offset", want.entry_offset, seen.entry_offset);
    compare_field("plain_size", want.plain_size, seen.plain_size);
    compare_field("packed_size", want.packed_size, seen.packed_size);
    compare_field("method", 64'(want.method), 64'(seen.method));
    compare_field("encrypted", 64'(want.encrypted), 64'(seen.encrypted));
    compare_field("chunk_size", want.chunk_size, seen.chunk_size);
    compare_field("chunk_count", 64'(want.chunk_count), 64'(seen.chunk_count));
    compare_field("chunk_start", want.chunk_start, seen.chunk_start);
    compare_field("chunk_end", want.chunk_end, seen.chunk_end);
    compare_field("last", 64'(want.last), 64'(seen.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  = pae_pkg::PhFlag;
      flag_q   = '0;
      low_q    = '0;
      bsize_q  = '0;
      offset_q = '0;
      plain_q  = '0;
      stored_q = '0;
      pos_q    = '0;
      left_q   = '0;
      results_q.delete();
      results_due_o <= 0;
    end else begin
      if (res_bus.valid && res_bus.ready) check_result();
      if (word_bus.valid && word_bus.ready) decode_word(word_bus.word);
      results_due_o <= results_q.size();
    end
  end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the packed archive entry decoder: clock, reset, stimulus, verdict.
// Depends on pae_pkg, pae_if.sv, the decoder RTL and pae_result_checker.
module tb_top;

  localparam int unsigned CycleLimit  = 3_000_000;
  localparam int unsigned RandomWords = 1750;

  logic        clk_i      = 1'b0;
  logic        rst_n      = 1'b0;
  logic        word_valid = 1'b0;
  logic [31:0] word_data  = '0;
  logic        sink_ready = 1'b0;
  logic        src_eager  = 1'b0;
  logic        sink_eager = 1'b0;
  int          hold_left  = 0;
  int          sink_stall;
  int unsigned fail_count;
  int unsigned results_due;
  int unsigned cycle_count = 0;
  int unsigned words_sent  = 0;

  pae_word_if word_bus ();
  pae_res_if  res_bus ();

  assign word_bus.valid = word_valid;
  assign word_bus.word  = word_data;
  assign res_bus.ready  = sink_ready;

  packed_archive_entry_decoder u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_n),
    .in_i   (word_bus),
    .out_o  (res_bus)
  );

  pae_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .word_bus      (word_bus),
    .res_bus       (res_bus),
    .fail_count_o  (fail_count),
    .results_due_o (results_due)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk_i) begin
    if (!rst_n) begin
      sink_ready <= 1'b0;
      hold_left  <= 0;
    end else if (!sink_ready) begin
      if (hold_left <= 1) sink_ready <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (res_bus.valid) begin
      if ($urandom_range(0, 49) == 0) sink_eager <= !sink_eager;
      sink_stall = sink_eager ? 0 : $urandom_range(0, 3);
      if (sink_stall != 0) begin
        sink_ready <= 1'b0;
        hold_left  <= sink_stall;
      end
    end
  end

  task automatic send_word(input logic [31:0] w);
    int unsigned gap;
    gap = src_eager ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      word_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    word_valid <= 1'b1;
    word_data  <= w;
    @(posedge clk_i);
    while (!word_bus.ready) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic send_entry(input logic off_one, input logic plain_one, input logic stored_one,
                            input logic enc, input logic [5:0] method, input logic [15:0] cnt,
                            input logic [5:0] code, input logic [31:0] bsize,
                            input logic [63:0] off, input logic [63:0] plain,
                            input logic [63:0] stored, input logic [31:0] sizes[$]);
    send_word({off_one, plain_one, stored_one, method, enc, cnt, code});
    if (code == pae_pkg::InlineSizeCode) send_word(bsize);
    send_word(off[31:0]);
    if (!off_one) send_word(off[63:32]);
    send_word(plain[31:0]);
    if (!plain_one) send_word(plain[63:32]);
    if (method != 6'd0) begin
      send_word(stored[31:0]);
      if (!stored_one) send_word(stored[63:32]);
    end
    if (cnt > 16'd1 || (cnt == 16'd1 && enc)) begin
      foreach (sizes[i]) send_word(sizes[i]);
    end
  endtask

  task automatic wait_drained();
    word_valid <= 1'b0;
    @(posedge clk_i);
    while (results_due != 0) @(posedge clk_i);
  endtask

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return {32'd0, $urandom};
      3:       return 64'($urandom_range(0, 255));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 4))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFF0 + $urandom_range(0, 15);
      2:       return $urandom;
      default: return $urandom_range(0, 4096);
    endcase
  endfunction

  task automatic send_random_entry();
    logic [15:0] cnt;
    logic [5:0]  method;
    logic [5:0]  code;
    logic        enc;
    logic [31:0] sizes[$];
    case ($urandom_range(0, 7))
      0:       cnt = 16'd0;
      1, 2:    cnt = 16'd1;
      3:       cnt = 16'($urandom_range(9, 64));
      default: cnt = 16'($urandom_range(2, 8));
    endcase
    method = ($urandom_range(0, 3) == 0) ? 6'd0 : 6'($urandom_range(1, 63));
    code   = ($urandom_range(0, 3) == 0) ? pae_pkg::InlineSizeCode : 6'($urandom);
    enc    = 1'($urandom);
    for (int i = 0; i < cnt; i++) sizes = {sizes, pick_size()};
    send_entry(1'($urandom), 1'($urandom), 1'($urandom), enc, method, cnt, code, $urandom,
               pick_value(), pick_value(), pick_value(), sizes);
  endtask

  initial begin
    logic [31:0] sizes[$];
    int unsigned random_end;
    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // no blocks, all one-word fields, zero values
    send_entry(1'b1, 1'b1, 1'b1, 1'b0, 6'd0, 16'd0, 6'd0, '0, '0, '0, '0, sizes);
    // single plain block, inline size, two-word fields, position wrap
    send_entry(1'b0, 1'b0, 1'b0, 1'b0, 6'd5, 16'd1, pae_pkg::InlineSizeCode, 32'hFFFF_FFFF,
               64'hFFFF_FFFF_FFFF_FFF0, '1, 64'h0123_4567_89AB_CDEF, sizes);
    // single encrypted block reads a size word
    sizes = {sizes, 32'hFFFF_FFFF};
    send_entry(1'b1, 1'b1, 1'b1, 1'b1, 6'd0, 16'd1, 6'd1, '0, 64'hFFFF_FFFF, 64'd123, '0,
               sizes);
    // encrypted, top method, rounding at both ends
    sizes.delete();
    sizes = {sizes, 32'd1};
    sizes = {sizes, 32'd16};
    sizes = {sizes, 32'hFFFF_FFF1};
    send_entry(1'b1, 1'b1, 1'b1, 1'b1, 6'd63, 16'd3, 6'h3E, '0, 64'd100, 64'd5000,
               64'hFFFF_FFFF, sizes);
    // method zero with blocks still reads size words
    sizes.delete();
    sizes = {sizes, 32'd0};
    sizes = {sizes, 32'hFFFF_FFFF};
    send_entry(1'b1, 1'b0, 1'b1, 1'b0, 6'd0, 16'd2, 6'd0, '0, 64'd7, '1, '0, sizes);
    wait_drained();

    random_end = words_sent + RandomWords;
    while (words_sent < random_end) begin
      if ($urandom_range(0, 9) == 0) src_eager = !src_eager;
      send_random_entry();
      if ($urandom_range(0, 39) == 0) wait_drained();
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
